FILE: design/hlg_pkg.sv
// Shared types, constants and register map for the core hotplug load governor.
// No dependencies; every other file in the design refers to this package by scoped names.
package hlg_pkg;

	// Number of cores the governor manages (core 0 included)
	localparam int CORE_COUNT = 4;

	// Field widths
	localparam int OP_W    = 2;
	localparam int LOAD_W  = 8;
	localparam int FREQ_W  = 22;
	localparam int LEVEL_W = 7;
	localparam int LIM_W   = 3;
	localparam int MASK_W  = 4;
	localparam int CNT_W   = 3;
	localparam int ACT_W   = 3;
	localparam int DWELL_W = 8;
	// Sum of three frequencies, and the scaled limit 3*L+2, both fit in 24 bits
	localparam int SUM_W   = FREQ_W + 2;

	// Stream and register port widths
	localparam int S_DATA_W = 104;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 24;
	localparam int ADDR_W   = 5;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = 3;

	// Request opcodes (code 3 is unused and ignored)
	localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
	localparam logic [OP_W-1:0] OP_SUSPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_RESUME  = 2'd2;

	// Action codes reported with each result
	localparam logic [ACT_W-1:0] ACT_NONE       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PLUG_ALL   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PLUG_ONE   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_UNPLUG_ONE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_UNPLUG_ALL = 3'd4;

	// Register indexes (byte address = 4 * index)
	localparam logic [REG_IDX_W-1:0] REG_ENABLE     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ALIVE      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PLUG_ONE   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PLUG_ALL   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MIN_DWELL  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FREQ_LIMIT = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_CORE_LIMIT = 3'd6;

	// Register reset values
	localparam logic                RST_ENABLE     = 1'b1;
	localparam logic [LEVEL_W-1:0]  RST_ALIVE      = 7'd10;
	localparam logic [LEVEL_W-1:0]  RST_PLUG_ONE   = 7'd20;
	localparam logic [LEVEL_W-1:0]  RST_PLUG_ALL   = 7'd70;
	localparam logic [LEVEL_W-1:0]  RST_MIN_DWELL  = 7'd8;
	localparam logic [FREQ_W-1:0]   RST_FREQ_LIMIT = 22'd1800000;
	localparam logic [LIM_W-1:0]    RST_CORE_LIMIT = 3'd4;

	// Governor state reset values and thresholds
	localparam logic [MASK_W-1:0]  BOOT_MASK         = 4'b0001;
	localparam logic [DWELL_W-1:0] DWELL_MAX         = 8'd255;
	localparam logic [CNT_W-1:0]   UNPLUG_CLEAR_BELOW = 3'd3;

	// Configuration register set
	typedef struct packed {
		logic               enable;
		logic [LEVEL_W-1:0] alive_level;
		logic [LEVEL_W-1:0] plug_one_level;
		logic [LEVEL_W-1:0] plug_all_level;
		logic [LEVEL_W-1:0] min_dwell_ticks;
		logic [FREQ_W-1:0]  freq_unplug_limit;
		logic [LIM_W-1:0]   core_limit;
	} cfg_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SUM   = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;  // latch the incoming request
		logic calc;     // register frequency sum and scaled limit
		logic apply;    // update governor state and load the result register
	} cmd_t;

endpackage

FILE: design/hlg_cfg.sv
// APB-style configuration register bank for the governor.
// Depends on hlg_pkg for the register map, widths and reset values.
module hlg_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hlg_pkg::ADDR_W-1:0]  paddr,
	input  logic [hlg_pkg::PDATA_W-1:0] pwdata,
	output logic [hlg_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output hlg_pkg::cfg_t               cfg
);

	hlg_pkg::cfg_t                  cfg_q;
	logic [hlg_pkg::REG_IDX_W-1:0]  idx;
	logic                           wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[hlg_pkg::ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable            <= hlg_pkg::RST_ENABLE;
			cfg_q.alive_level       <= hlg_pkg::RST_ALIVE;
			cfg_q.plug_one_level    <= hlg_pkg::RST_PLUG_ONE;
			cfg_q.plug_all_level    <= hlg_pkg::RST_PLUG_ALL;
			cfg_q.min_dwell_ticks   <= hlg_pkg::RST_MIN_DWELL;
			cfg_q.freq_unplug_limit <= hlg_pkg::RST_FREQ_LIMIT;
			cfg_q.core_limit        <= hlg_pkg::RST_CORE_LIMIT;
		end else if (wr_en) begin
			unique case (idx)
				hlg_pkg::REG_ENABLE:     cfg_q.enable <= pwdata[0];
				hlg_pkg::REG_ALIVE:      cfg_q.alive_level <= pwdata[hlg_pkg::LEVEL_W-1:0];
				hlg_pkg::REG_PLUG_ONE:   cfg_q.plug_one_level <= pwdata[hlg_pkg::LEVEL_W-1:0];
				hlg_pkg::REG_PLUG_ALL:   cfg_q.plug_all_level <= pwdata[hlg_pkg::LEVEL_W-1:0];
				hlg_pkg::REG_MIN_DWELL:  cfg_q.min_dwell_ticks <= pwdata[hlg_pkg::LEVEL_W-1:0];
				hlg_pkg::REG_FREQ_LIMIT: cfg_q.freq_unplug_limit <= pwdata[hlg_pkg::FREQ_W-1:0];
				hlg_pkg::REG_CORE_LIMIT: cfg_q.core_limit <= pwdata[hlg_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			hlg_pkg::REG_ENABLE:     prdata = hlg_pkg::PDATA_W'(cfg_q.enable);
			hlg_pkg::REG_ALIVE:      prdata = hlg_pkg::PDATA_W'(cfg_q.alive_level);
			hlg_pkg::REG_PLUG_ONE:   prdata = hlg_pkg::PDATA_W'(cfg_q.plug_one_level);
			hlg_pkg::REG_PLUG_ALL:   prdata = hlg_pkg::PDATA_W'(cfg_q.plug_all_level);
			hlg_pkg::REG_MIN_DWELL:  prdata = hlg_pkg::PDATA_W'(cfg_q.min_dwell_ticks);
			hlg_pkg::REG_FREQ_LIMIT: prdata = hlg_pkg::PDATA_W'(cfg_q.freq_unplug_limit);
			hlg_pkg::REG_CORE_LIMIT: prdata = hlg_pkg::PDATA_W'(cfg_q.core_limit);
			default:                 prdata = '0;
		endcase
	end

endmodule

FILE: design/hlg_ctrl.sv
// Sequencing state machine for the governor: accept, sum, apply and result handshake.
// Depends on hlg_pkg for the state and command types.
module hlg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output hlg_pkg::cmd_t cmd
);

	hlg_pkg::state_t state_q, state_d;
	logic            m_tvalid_q;
	logic            accept;
	logic            out_free;

	assign s_tready = (state_q == hlg_pkg::ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.calc    = 1'b0;
		cmd.apply   = 1'b0;
		unique case (state_q)
			hlg_pkg::ST_IDLE: begin
				cmd.capture = accept;
				if (accept) state_d = hlg_pkg::ST_SUM;
			end
			hlg_pkg::ST_SUM: begin
				cmd.calc = 1'b1;
				state_d  = hlg_pkg::ST_APPLY;
			end
			hlg_pkg::ST_APPLY: begin
				// wait until the result register can take the new result
				cmd.apply = out_free;
				if (out_free) state_d = hlg_pkg::ST_IDLE;
			end
			default: state_d = hlg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hlg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.apply) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_to_sum: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == hlg_pkg::ST_SUM))
		else $error("accepted request did not move to sum state");
	a_apply_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hlg_pkg::ST_APPLY && m_tvalid_q && !m_tready)
		|=> (state_q == hlg_pkg::ST_APPLY && m_tvalid_q))
		else $error("apply left while the result register was still full");
`endif

endmodule

FILE: design/hlg_dp.sv
// Governor datapath: request capture, frequency check, mask/dwell update, result register.
// Depends on hlg_pkg for widths, codes and the config and command types.
module hlg_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hlg_pkg::cmd_t               cmd,
	input  hlg_pkg::cfg_t               cfg,
	input  logic [hlg_pkg::OP_W-1:0]    op,
	input  logic [hlg_pkg::LOAD_W-1:0]  load_value,
	input  logic [hlg_pkg::FREQ_W-1:0]  freq_core_one,
	input  logic [hlg_pkg::FREQ_W-1:0]  freq_core_two,
	input  logic [hlg_pkg::FREQ_W-1:0]  freq_core_three,
	input  logic                        policy_valid,
	input  logic [hlg_pkg::FREQ_W-1:0]  policy_min_freq,
	output logic [hlg_pkg::MASK_W-1:0]  online_mask,
	output logic [hlg_pkg::CNT_W-1:0]   online_count,
	output logic [hlg_pkg::ACT_W-1:0]   action,
	output logic [hlg_pkg::DWELL_W-1:0] dwell_count
);

	// Captured request
	logic [hlg_pkg::OP_W-1:0]   op_q;
	logic [hlg_pkg::LOAD_W-1:0] load_q;
	logic [hlg_pkg::FREQ_W-1:0] freq_q [1:3];
	logic                       pol_valid_q;
	logic [hlg_pkg::FREQ_W-1:0] pol_min_q;

	// Frequency check intermediates
	logic [hlg_pkg::SUM_W-1:0]  sum_q, sum_d;
	logic [hlg_pkg::SUM_W-1:0]  thr_q, thr_d;
	logic                       fblock_q, fblock_d;

	// Governor state
	logic [hlg_pkg::MASK_W-1:0]  mask_q, mask_d;
	logic [hlg_pkg::DWELL_W-1:0] dwell_q, dwell_d;
	logic                        susp_q, susp_d;

	// Result register
	logic [hlg_pkg::MASK_W-1:0]  out_mask_q;
	logic [hlg_pkg::CNT_W-1:0]   out_count_q;
	logic [hlg_pkg::ACT_W-1:0]   out_act_q;
	logic [hlg_pkg::DWELL_W-1:0] out_dwell_q;

	logic [hlg_pkg::LIM_W-1:0]   lim;
	logic [1:0]                  div;
	logic [hlg_pkg::SUM_W-1:0]   lim_ext;
	logic                        freq_over;
	logic [hlg_pkg::ACT_W-1:0]   act_d;

	// Clamp core limit into 1..CORE_COUNT
	always_comb begin
		if (cfg.core_limit == '0) begin
			lim = hlg_pkg::LIM_W'(1);
		end else if (cfg.core_limit > hlg_pkg::LIM_W'(hlg_pkg::CORE_COUNT)) begin
			lim = hlg_pkg::LIM_W'(hlg_pkg::CORE_COUNT);
		end else begin
			lim = cfg.core_limit;
		end
	end
	assign div     = 2'(lim - hlg_pkg::LIM_W'(1));
	assign lim_ext = hlg_pkg::SUM_W'(cfg.freq_unplug_limit);

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q        <= op;
			load_q      <= load_value;
			freq_q[1]   <= freq_core_one;
			freq_q[2]   <= freq_core_two;
			freq_q[3]   <= freq_core_three;
			pol_valid_q <= policy_valid;
			pol_min_q   <= policy_min_freq;
		end
	end

	// Secondary frequency sum; mean > L is checked as sum > div*L + div - 1
	always_comb begin
		sum_d = '0;
		for (int c = 1; c <= 3; c++) begin
			if (hlg_pkg::LIM_W'(c) < lim) sum_d = sum_d + hlg_pkg::SUM_W'(freq_q[c]);
		end
		case (div)
			2'd1:    thr_d = lim_ext;
			2'd2:    thr_d = (lim_ext << 1) + hlg_pkg::SUM_W'(1);
			2'd3:    thr_d = (lim_ext << 1) + lim_ext + hlg_pkg::SUM_W'(2);
			default: thr_d = '0;
		endcase
		fblock_d = (pol_valid_q && (pol_min_q > cfg.freq_unplug_limit)) || (div == 2'd0);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			sum_q    <= sum_d;
			thr_q    <= thr_d;
			fblock_q <= fblock_d;
		end
	end

	assign freq_over = !fblock_q && (sum_q > thr_q);

	// Governor decision
	always_comb begin
		logic [hlg_pkg::CNT_W-1:0]   online;
		logic [hlg_pkg::DWELL_W-1:0] dwell_inc;
		logic [hlg_pkg::MASK_W-1:0]  m;
		logic                        found;
		online    = hlg_pkg::CNT_W'($countones(mask_q));
		dwell_inc = dwell_q;
		m         = mask_q;
		found     = 1'b0;
		mask_d    = mask_q;
		dwell_d   = dwell_q;
		susp_d    = susp_q;
		act_d     = hlg_pkg::ACT_NONE;
		if (op_q == hlg_pkg::OP_SUSPEND) begin
			susp_d = 1'b1;
		end else if (op_q == hlg_pkg::OP_RESUME) begin
			susp_d = 1'b0;
		end else if (op_q == hlg_pkg::OP_TICK && cfg.enable) begin
			if (online > hlg_pkg::CNT_W'(1) && dwell_q < hlg_pkg::DWELL_MAX)
				dwell_inc = dwell_q + hlg_pkg::DWELL_W'(1);
			dwell_d = dwell_inc;
			if (susp_q) begin
				m       = hlg_pkg::BOOT_MASK;
				dwell_d = '0;
				act_d   = hlg_pkg::ACT_UNPLUG_ALL;
			end else if (load_q >= {1'b0, cfg.plug_all_level}) begin
				if (online < lim) begin
					for (int c = 1; c <= 3; c++) begin
						if (hlg_pkg::LIM_W'(c) < lim) m[c] = 1'b1;
					end
				end
				act_d = hlg_pkg::ACT_PLUG_ALL;
			end else if (load_q >= {1'b0, cfg.plug_one_level}) begin
				// lowest offline core below the limit
				if (online < lim) begin
					for (int c = 1; c <= 3; c++) begin
						if (!found && hlg_pkg::LIM_W'(c) < lim && !m[c]) begin
							m[c]  = 1'b1;
							found = 1'b1;
						end
					end
				end
				act_d = hlg_pkg::ACT_PLUG_ONE;
			end else if (load_q < {1'b0, cfg.alive_level} && online > hlg_pkg::CNT_W'(1)
					&& !freq_over && dwell_inc > {1'b0, cfg.min_dwell_ticks}) begin
				if (online < hlg_pkg::UNPLUG_CLEAR_BELOW) dwell_d = '0;
				// highest online core below the limit
				for (int c = 3; c >= 1; c--) begin
					if (!found && hlg_pkg::LIM_W'(c) < lim && m[c]) begin
						m[c]  = 1'b0;
						found = 1'b1;
					end
				end
				act_d = hlg_pkg::ACT_UNPLUG_ONE;
			end
			mask_d = m | hlg_pkg::BOOT_MASK;
			if (mask_d == mask_q) act_d = hlg_pkg::ACT_NONE;
		end
	end

	// Governor state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= hlg_pkg::BOOT_MASK;
			dwell_q <= '0;
			susp_q  <= 1'b0;
		end else if (cmd.apply) begin
			mask_q  <= mask_d;
			dwell_q <= dwell_d;
			susp_q  <= susp_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			out_mask_q  <= mask_d;
			out_count_q <= hlg_pkg::CNT_W'($countones(mask_d));
			out_act_q   <= act_d;
			out_dwell_q <= dwell_d;
		end
	end

	assign online_mask  = out_mask_q;
	assign online_count = out_count_q;
	assign action       = out_act_q;
	assign dwell_count  = out_dwell_q;

`ifndef NO_ASSERTIONS
	a_core0_online: assert property (@(posedge clk) disable iff (!arst_n)
		mask_q[0])
		else $error("core 0 went offline");
	a_suspend_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && op_q == hlg_pkg::OP_TICK && cfg.enable && susp_q)
		|=> (mask_q == hlg_pkg::BOOT_MASK && dwell_q == '0))
		else $error("suspended tick did not drop secondaries and clear dwell");
`endif

endmodule

FILE: design/core_hotplug_load_governor.sv
// Top level of the core hotplug load governor: stream ports, APB config, ctrl and datapath.
// Depends on hlg_pkg, hlg_cfg, hlg_ctrl and hlg_dp.
//
// Channel   Direction  Handshake            Content
// s_*       in         s_tvalid / s_tready  one governor request (op in tuser)
// m_*       out        m_tvalid / m_tready  one result per request
// APB       in/out     psel, penable        seven configuration registers at 4*i
//
// Each request passes through three steps: capture, frequency sum/limit, state update into
// the result register. The next request is accepted once the update is done,
// even while the previous result still waits in the output register.
// A full output register stalls the update cycle until m_tready.
// Reset (arst_n low) clears the mask to core 0 only, the dwell counter, the
// suspend flag and both valid/state flags; registers take their reset values.
module core_hotplug_load_governor (
	input  logic                         clk,
	input  logic                         arst_n,
	// s_tdata: load_value[7:0], freq_core_one[29:8], freq_core_two[51:30],
	//          freq_core_three[73:52], policy_valid[74], policy_min_freq[96:75], zero pad
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [hlg_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [hlg_pkg::S_USER_W-1:0] s_tuser,  // op[1:0]
	// m_tdata: online_mask[3:0], online_count[6:4], action[9:7], dwell_count[17:10], zero pad
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [hlg_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hlg_pkg::ADDR_W-1:0]   paddr,
	input  logic [hlg_pkg::PDATA_W-1:0]  pwdata,
	output logic [hlg_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	hlg_pkg::cfg_t cfg;
	hlg_pkg::cmd_t cmd;

	logic [hlg_pkg::MASK_W-1:0]  online_mask;
	logic [hlg_pkg::CNT_W-1:0]   online_count;
	logic [hlg_pkg::ACT_W-1:0]   action;
	logic [hlg_pkg::DWELL_W-1:0] dwell_count;

	hlg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hlg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	hlg_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg),
		.op              (s_tuser[1:0]),
		.load_value      (s_tdata[7:0]),
		.freq_core_one   (s_tdata[29:8]),
		.freq_core_two   (s_tdata[51:30]),
		.freq_core_three (s_tdata[73:52]),
		.policy_valid    (s_tdata[74]),
		.policy_min_freq (s_tdata[96:75]),
		.online_mask     (online_mask),
		.online_count    (online_count),
		.action          (action),
		.dwell_count     (dwell_count)
	);

	// Pack the result
	assign m_tdata = {6'd0, dwell_count, action, online_count, online_mask};

endmodule

FILE: test/hlg_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the core hotplug load governor: mirrors register writes, predicts one
// status report per accepted request and compares it with the output stream.
// Depends on hlg_pkg for widths, opcodes, action codes, register indexes and reset values.
module hlg_result_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [hlg_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [hlg_pkg::S_USER_W-1:0] s_tuser,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [hlg_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [hlg_pkg::ADDR_W-1:0]   paddr,
	input  logic [hlg_pkg::PDATA_W-1:0]  pwdata,
	output int                           mismatch_count,
	output int                           outstanding,
	output int                           reports_checked
);
	import hlg_pkg::*;

	// One status report, packed as on m_tdata
	typedef struct packed {
		logic [DWELL_W-1:0] dwell;
		logic [ACT_W-1:0]   action;
		logic [CNT_W-1:0]   count;
		logic [MASK_W-1:0]  mask;
	} status_t;

	cfg_t               gov_cfg;
	logic [MASK_W-1:0]  online_q;
	logic [DWELL_W-1:0] dwell_q;
	logic               suspended_q;
	status_t            queued_status[$];
	status_t            got, want;

	// Core limit clamped to 1..CORE_COUNT
	function automatic int unsigned usable_cores();
		if (gov_cfg.core_limit < 1) return 1;
		if (gov_cfg.core_limit > CORE_COUNT) return CORE_COUNT;
		return gov_cfg.core_limit;
	endfunction

	// True when the mean secondary frequency blocks an unplug
	function automatic bit mean_freq_high(input logic [S_DATA_W-1:0] d, input int unsigned lim);
		logic [FREQ_W-1:0] f1, f2, f3, pmin;
		longint unsigned   sum;
		f1   = d[29:8];
		f2   = d[51:30];
		f3   = d[73:52];
		pmin = d[96:75];
		// a valid policy minimum above the limit disables the check
		if (d[74] && pmin > gov_cfg.freq_unplug_limit) return 1'b0;
		if (lim <= 1) return 1'b0;
		sum = f1;
		if (lim > 2) sum += f2;
		if (lim > 3) sum += f3;
		sum = sum / (lim - 1);
		return sum > gov_cfg.freq_unplug_limit;
	endfunction

	// Update the governor state for one request and queue the report it gives
	task automatic advance_governor(input logic [OP_W-1:0] op, input logic [S_DATA_W-1:0] d);
		logic [LOAD_W-1:0] load;
		logic [MASK_W-1:0] mask, prior;
		logic [ACT_W-1:0]  act;
		int unsigned       lim, online;
		status_t           st;
		load  = d[LOAD_W-1:0];
		prior = online_q;
		act   = ACT_NONE;
		if (op == OP_SUSPEND) begin
			suspended_q = 1'b1;
		end else if (op == OP_RESUME) begin
			suspended_q = 1'b0;
		end else if (op == OP_TICK && gov_cfg.enable) begin
			lim    = usable_cores();
			online = $countones(online_q);
			mask   = online_q;
			if (online > 1 && dwell_q != DWELL_MAX) dwell_q++;
			if (suspended_q) begin
				// suspended: drop every secondary core, limit or not
				mask    = BOOT_MASK;
				dwell_q = '0;
				act     = ACT_UNPLUG_ALL;
			end else if (load >= gov_cfg.plug_all_level) begin
				if (online < lim)
					for (int c = 1; c < lim; c++) mask[c] = 1'b1;
				act = ACT_PLUG_ALL;
			end else if (load >= gov_cfg.plug_one_level) begin
				// lowest offline core below the limit
				if (online < lim)
					for (int c = 1; c < lim; c++)
						if (!mask[c]) begin
							mask[c] = 1'b1;
							break;
						end
				act = ACT_PLUG_ONE;
			end else if (load < gov_cfg.alive_level && online > 1 && !mean_freq_high(d, lim)
					&& dwell_q > gov_cfg.min_dwell_ticks) begin
				if (online < UNPLUG_CLEAR_BELOW) dwell_q = '0;
				// highest online core below the limit
				for (int c = lim - 1; c > 0; c--)
					if (mask[c]) begin
						mask[c] = 1'b0;
						break;
					end
				act = ACT_UNPLUG_ONE;
			end
			online_q = mask | BOOT_MASK;
			// an action that moved no core reports none
			if (online_q == prior) act = ACT_NONE;
		end
		st.mask   = online_q;
		st.count  = CNT_W'($countones(online_q));
		st.action = act;
		st.dwell  = dwell_q;
		queued_status.push_back(st);
	endtask

	function automatic void compare_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endfunction

	// Watch both streams and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gov_cfg = '{enable: RST_ENABLE, alive_level: RST_ALIVE, plug_one_level: RST_PLUG_ONE,
				plug_all_level: RST_PLUG_ALL, min_dwell_ticks: RST_MIN_DWELL,
				freq_unplug_limit: RST_FREQ_LIMIT, core_limit: RST_CORE_LIMIT};
			online_q        = BOOT_MASK;
			dwell_q         = '0;
			suspended_q     = 1'b0;
			queued_status.delete();
			mismatch_count  = 0;
			outstanding     = 0;
			reports_checked = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = status_t'(m_tdata[$bits(status_t)-1:0]);
				if (queued_status.size() == 0) begin
					$display("%0t: unexpected report: expected none, got %h", $time, got);
					mismatch_count++;
				end else begin
					want = queued_status.pop_front();
					compare_field("online_mask", want.mask, got.mask);
					compare_field("online_count", want.count, got.count);
					compare_field("action", want.action, got.action);
					compare_field("dwell_count", want.dwell, got.dwell);
					reports_checked++;
				end
			end
			if (s_tvalid && s_tready) advance_governor(s_tuser, s_tdata);
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_ENABLE:     gov_cfg.enable            = pwdata[0];
					REG_ALIVE:      gov_cfg.alive_level       = pwdata[LEVEL_W-1:0];
					REG_PLUG_ONE:   gov_cfg.plug_one_level    = pwdata[LEVEL_W-1:0];
					REG_PLUG_ALL:   gov_cfg.plug_all_level    = pwdata[LEVEL_W-1:0];
					REG_MIN_DWELL:  gov_cfg.min_dwell_ticks   = pwdata[LEVEL_W-1:0];
					REG_FREQ_LIMIT: gov_cfg.freq_unplug_limit = pwdata[FREQ_W-1:0];
					REG_CORE_LIMIT: gov_cfg.core_limit        = pwdata[LIM_W-1:0];
					default: ;
				endcase
			end
			outstanding = queued_status.size();
		end
	end

endmodule

FILE: test/core_hotplug_load_governor_tb.sv
`timescale 1ns / 1ps
// Testbench top for the core hotplug load governor: clock, reset, register setup,
// request stimulus and verdict. Depends on hlg_pkg, the design and hlg_result_checker.
module core_hotplug_load_governor_tb;
	import hlg_pkg::*;

	localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;
	localparam logic [FREQ_W-1:0] FREQ_MAX     = '1;
	localparam logic [FREQ_W-1:0] FREQ_LOW     = 22'd500000;
	localparam int                PHASES       = 10;
	localparam int                DRAIN_CYCLES = 20;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic [S_USER_W-1:0] s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [ADDR_W-1:0]   paddr    = '0;
	logic [PDATA_W-1:0]  pwdata   = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	int mismatch_count, outstanding, reports_checked;
	int requests_sent = 0;
	int writes_done   = 0;
	bit idling        = 1'b1;

	// Level copies used to aim loads at each band
	int unsigned lv_alive = RST_ALIVE;
	int unsigned lv_one   = RST_PLUG_ONE;
	int unsigned lv_all   = RST_PLUG_ALL;
	int unsigned freq_lim = RST_FREQ_LIMIT;

	int unsigned stall_left = 0;

	core_hotplug_load_governor uut (.*);

	hlg_result_checker checker_i (.*);

	always #1 clk = ~clk;

	// Output side: random stall bursts, started only while idling
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idling && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 9);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		writes_done++;
	endtask

	task automatic load_settings(input int unsigned en, input int unsigned alive,
			input int unsigned one, input int unsigned all, input int unsigned dwell,
			input int unsigned flim, input int unsigned climit);
		reg_write(REG_ENABLE, en);
		reg_write(REG_ALIVE, alive);
		reg_write(REG_PLUG_ONE, one);
		reg_write(REG_PLUG_ALL, all);
		reg_write(REG_MIN_DWELL, dwell);
		reg_write(REG_FREQ_LIMIT, flim);
		reg_write(REG_CORE_LIMIT, climit);
		lv_alive = alive;
		lv_one   = one;
		lv_all   = all;
		freq_lim = flim;
	endtask

	// Present one request, with an optional gap first, and wait for it to be taken
	task automatic send_request(input logic [OP_W-1:0] op, input logic [LOAD_W-1:0] load,
			input logic [FREQ_W-1:0] f1, input logic [FREQ_W-1:0] f2,
			input logic [FREQ_W-1:0] f3, input logic pv, input logic [FREQ_W-1:0] pmin);
		int unsigned gap;
		gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, pmin, pv, f3, f2, f1, load};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		requests_sent++;
	endtask

	// Random request: mostly ticks, loads aimed at the level bands
	task automatic send_random(input bit allow_suspend);
		logic [OP_W-1:0]   op;
		logic [LOAD_W-1:0] load;
		logic [FREQ_W-1:0] f1, f2, f3, pmin;
		logic              pv;
		int unsigned       pick;
		pick = $urandom_range(0, 99);
		if (pick < 84) op = OP_TICK;
		else if (pick < 90) op = allow_suspend ? OP_SUSPEND : OP_TICK;
		else if (pick < 97) op = OP_RESUME;
		else op = OP_UNUSED;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: load = LOAD_W'($urandom_range(0, lv_alive));
			4, 5:       load = LOAD_W'($urandom_range(lv_alive, lv_one));
			6, 7:       load = LOAD_W'($urandom_range(lv_one, lv_all));
			8:          load = LOAD_W'($urandom_range(lv_all, 255));
			default:    load = LOAD_W'($urandom_range(0, 255));
		endcase
		case ($urandom_range(0, 3))
			0: begin
				f1 = FREQ_W'($urandom_range(0, freq_lim));
				f2 = FREQ_W'($urandom_range(0, freq_lim));
				f3 = FREQ_W'($urandom_range(0, freq_lim));
			end
			1: begin
				// mean right around the limit
				f1 = FREQ_W'(freq_lim + $urandom_range(0, 6) - 3);
				f2 = FREQ_W'(freq_lim + $urandom_range(0, 6) - 3);
				f3 = FREQ_W'(freq_lim + $urandom_range(0, 6) - 3);
			end
			2: begin
				f1 = FREQ_W'($urandom);
				f2 = FREQ_W'($urandom);
				f3 = FREQ_W'($urandom);
			end
			default: begin
				f1 = $urandom_range(0, 1) ? FREQ_MAX : '0;
				f2 = $urandom_range(0, 1) ? FREQ_MAX : '0;
				f3 = $urandom_range(0, 1) ? FREQ_MAX : '0;
			end
		endcase
		pv   = 1'($urandom_range(0, 1));
		pmin = $urandom_range(0, 1) ? FREQ_W'($urandom_range(0, freq_lim)) : FREQ_W'($urandom);
		send_request(op, load, f1, f2, f3, pv, pmin);
	endtask

	// Let every report come back before touching the registers
	task automatic wait_quiet();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, reset settings: plug paths, suspend, unplug gates
		send_request(OP_TICK, 8'd0, '0, '0, '0, 1'b0, '0);
		send_request(OP_TICK, 8'd255, FREQ_MAX, FREQ_MAX, FREQ_MAX, 1'b1, FREQ_MAX);
		send_request(OP_TICK, 8'd255, FREQ_LOW, FREQ_LOW, FREQ_LOW, 1'b0, '0);
		send_request(OP_SUSPEND, 8'd0, '0, '0, '0, 1'b0, '0);
		send_request(OP_TICK, 8'd0, FREQ_LOW, FREQ_LOW, FREQ_LOW, 1'b0, '0);
		send_request(OP_TICK, 8'd255, FREQ_LOW, FREQ_LOW, FREQ_LOW, 1'b0, '0);
		send_request(OP_RESUME, 8'd0, '0, '0, '0, 1'b0, '0);
		send_request(OP_TICK, 8'd20, FREQ_LOW, FREQ_LOW, FREQ_LOW, 1'b0, '0);
		send_request(OP_TICK, 8'd69, FREQ_LOW, FREQ_LOW, FREQ_LOW, 1'b0, '0);
		send_request(OP_TICK, 8'd70, FREQ_LOW, FREQ_LOW, FREQ_LOW, 1'b0, '0);
		// high secondary clocks hold the cores while the dwell builds up
		repeat (6) send_request(OP_TICK, 8'd0, FREQ_MAX, FREQ_MAX, FREQ_MAX, 1'b0, '0);
		send_request(OP_TICK, 8'd0, FREQ_MAX, FREQ_MAX, FREQ_MAX, 1'b1, '0);
		send_request(OP_TICK, 8'd10, FREQ_LOW, FREQ_LOW, FREQ_LOW, 1'b0, '0);
		// policy minimum above the limit lifts the frequency block
		send_request(OP_TICK, 8'd0, FREQ_MAX, FREQ_MAX, FREQ_MAX, 1'b1, FREQ_MAX);
		send_request(OP_TICK, 8'd0, FREQ_LOW, FREQ_LOW, FREQ_LOW, 1'b0, '0);
		send_request(OP_TICK, 8'd0, FREQ_LOW, FREQ_LOW, FREQ_LOW, 1'b1, '0);
		send_request(OP_UNUSED, 8'd255, FREQ_MAX, '0, FREQ_MAX, 1'b1, FREQ_MAX);
		send_request(OP_TICK, 8'd19, FREQ_LOW, FREQ_LOW, FREQ_LOW, 1'b0, '0);

		// Random part over a range of settings; last phase runs without idling
		for (int p = 0; p < PHASES; p++) begin
			wait_quiet();
			idling = (p != PHASES - 1);
			case (p)
				0: load_settings(1, 10, 20, 70, 8, 1800000, 4);
				1: load_settings(1, 30, 50, 90, 0, 4194303, 4);
				2: load_settings(1, 10, 20, 70, 3, 0, 1);
				3: load_settings(1, 15, 25, 60, 2, 1000000, 0);
				4: load_settings(1, 20, 40, 80, 5, 2000000, 7);
				5: load_settings(1, 0, 100, 100, 127, 1800000, 4);  // dwell runs to saturation
				6: load_settings(0, 10, 20, 70, 4, 1800000, 4);
				7: load_settings(1, 127, 127, 127, 0, 3000000, 3);
				8: load_settings(1, 50, 0, 0, 1, 2500000, 2);
				default: load_settings(1, 12, 30, 60, 6, 1500000, 5);
			endcase
			repeat (p == 5 ? 400 : 180) send_random(p != 5);
		end
		wait_quiet();

		$display("Run covered %0d requests and %0d checked reports over %0d settings (%0d writes).",
			requests_sent, reports_checked, PHASES + 1, writes_done);
		$display("Settings spanned core limits 0 to 7, governor off, zero and full levels.");
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#1000000;
		$display("tb: failure");
		$finish;
	end

endmodule
